// ----- src/hcci_pkg.sv -----
package hcci_pkg;

	// field widths
	localparam int CNT_W     = 11;
	localparam int ID_W      = 30;
	localparam int PID_W     = 31;
	localparam int CK_W      = 21;
	localparam int CORNER_W  = 3;

	// derived widths
	localparam int PX_W      = CNT_W + 1;
	localparam int PPLANE_W  = 2 * PX_W;
	localparam int PLANE_W   = 2 * CNT_W;
	localparam int TOTAL_W   = PLANE_W + CNT_W;

	// restoring divider: quotient bits, steps per cycle
	localparam int QUO_W     = CNT_W + 1;
	localparam int DIV_STEPS = 4;
	localparam int DIV_CYC   = QUO_W / DIV_STEPS;
	localparam int DSH_W     = PLANE_W + QUO_W - 1;

	// config register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z = 2'd2;

	// hexahedron corner order, bit q is the offset of corner q
	localparam int NUM_CORNERS = 8;
	localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(NUM_CORNERS - 1);
	localparam logic [NUM_CORNERS-1:0] CORNER_DI = 8'b0110_0110;
	localparam logic [NUM_CORNERS-1:0] CORNER_DJ = 8'b1100_1100;
	localparam logic [NUM_CORNERS-1:0] CORNER_DK = 8'b1111_0000;

	// one classified cell, front to back
	typedef struct packed {
		logic             oor;
		logic [PID_W-1:0] base;
		logic [CNT_W-1:0] ci;
		logic [CNT_W-1:0] cj;
		logic [CNT_W-1:0] ck;
	} cell_t;

	typedef struct packed {
		logic [ID_W-1:0]  rem;
		logic [QUO_W-1:0] quo;
	} div_t;

	// zero reads as one, above the limit saturates
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v, input int limit);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (int'(v) > limit) begin
			r = CNT_W'(limit);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// a few restoring steps, divisor pre-shifted to the current quotient bit
	function automatic div_t div_step(input logic [ID_W-1:0] rem, input logic [DSH_W-1:0] dsh,
			input logic [QUO_W-1:0] quo);
		div_t r;
		logic [DSH_W-1:0] d;
		logic hit;
		r.rem = rem;
		r.quo = quo;
		for (int s = 0; s < DIV_STEPS; s++) begin
			d = dsh >> s;
			hit = (DSH_W'(r.rem) >= d);
			if (hit) begin
				r.rem = r.rem - d[ID_W-1:0];
			end
			r.quo = {r.quo[QUO_W-2:0], hit};
		end
		return r;
	endfunction

endpackage

// ----- src/hcci_in_if.sv -----
interface hcci_in_if;
	logic                      valid;
	logic                      ready;
	logic [hcci_pkg::ID_W-1:0] cell_id;

	modport source (output valid, output cell_id, input ready);
	modport sink (input valid, input cell_id, output ready);
endinterface

// ----- src/hcci_out_if.sv -----
interface hcci_out_if;
	logic                          valid;
	logic                          ready;
	logic [hcci_pkg::CORNER_W-1:0] corner;
	logic [hcci_pkg::PID_W-1:0]    point_id;
	logic [hcci_pkg::CNT_W-1:0]    corner_i;
	logic [hcci_pkg::CNT_W-1:0]    corner_j;
	logic [hcci_pkg::CK_W-1:0]     corner_k;
	logic                          out_of_range;
	logic                          last;

	modport source (output valid, output corner, output point_id, output corner_i,
		output corner_j, output corner_k, output out_of_range, output last, input ready);
	modport sink (input valid, input corner, input point_id, input corner_i,
		input corner_j, input corner_k, input out_of_range, input last, output ready);
endinterface

// ----- src/hex_cell_corner_indices_unit.sv -----
// path: an accepted cell id is divided in the front, multiplied to a base point id, queued,
// then sent as eight registered corner beats; one corner beat per cycle while corners.ready
// holds, and the front divider cannot take a new cell id until it has finished the last one
// reset: arst_n async active low, cell counts return to 1, queue and output stage empty,
// no clearing pass, ready right after reset
module hex_cell_corner_indices_unit #(
	parameter int AXIS_CELLS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	hcci_in_if.sink                          cells,
	hcci_out_if.source                       corners,
	input  logic                             cfg_wr_en,
	input  logic [hcci_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hcci_pkg::CNT_W-1:0]       cfg_wdata
);

	localparam int CNT_W    = hcci_pkg::CNT_W;
	localparam int PX_W     = hcci_pkg::PX_W;
	localparam int PPLANE_W = hcci_pkg::PPLANE_W;

	// configured cell counts, kept as written
	logic [CNT_W-1:0]    cells_x_q;
	logic [CNT_W-1:0]    cells_y_q;
	logic [CNT_W-1:0]    cells_z_q;

	// counts clamped to 1..AXIS_CELLS
	logic [CNT_W-1:0]    nx_eff;
	logic [CNT_W-1:0]    ny_eff;
	logic [CNT_W-1:0]    nz_eff;

	// point lattice strides, read by the front's multiply step and by the back's corner point ids
	logic [PX_W-1:0]     px_c;
	logic [PX_W-1:0]     py_c;
	logic [PX_W-1:0]     px_q;
	logic [PPLANE_W-1:0] pplane_q;

	// front to queue, queue to back
	logic                push_valid;
	hcci_pkg::cell_t     push_data;
	logic                push_ready;
	logic                pop_valid;
	hcci_pkg::cell_t     pop_data;
	logic                pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q <= CNT_W'(1);
			cells_y_q <= CNT_W'(1);
			cells_z_q <= CNT_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				hcci_pkg::CFG_CELLS_X: cells_x_q <= cfg_wdata;
				hcci_pkg::CFG_CELLS_Y: cells_y_q <= cfg_wdata;
				hcci_pkg::CFG_CELLS_Z: cells_z_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign nx_eff = hcci_pkg::eff_count(cells_x_q, AXIS_CELLS);
	assign ny_eff = hcci_pkg::eff_count(cells_y_q, AXIS_CELLS);
	assign nz_eff = hcci_pkg::eff_count(cells_z_q, AXIS_CELLS);

	// strides are registered from the cell count registers, the front reads them in its multiply state
	assign px_c = PX_W'(nx_eff) + PX_W'(1);
	assign py_c = PX_W'(ny_eff) + PX_W'(1);

	always_ff @(posedge clk) begin
		px_q     <= px_c;
		pplane_q <= PPLANE_W'(px_c) * PPLANE_W'(py_c);
	end

	// front: range check, id split by plane then by row, base point id
	hcci_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cells      (cells),
		.nx_eff     (nx_eff),
		.ny_eff     (ny_eff),
		.nz_eff     (nz_eff),
		.px         (px_q),
		.pplane     (pplane_q),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	// two-entry queue lets the front start the next id while corners go out
	hcci_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop        (pop)
	);

	// back: eight corner beats per cell through a registered output stage
	hcci_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop       (pop),
		.px        (px_q),
		.pplane    (pplane_q),
		.corners   (corners)
	);

`ifndef SYNTHESIS
	// an out of range cell gives zero coordinates and point ids
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		corners.valid && corners.out_of_range |->
		corners.point_id == '0 && corners.corner_i == '0 && corners.corner_j == '0
		&& corners.corner_k == '0)
		else $error("out of range beat with nonzero coordinates");

	// corners of one cell come back to back and in order
	a_corner_seq: assert property (@(posedge clk) disable iff (!arst_n)
		corners.valid && corners.ready && !corners.last |=>
		corners.valid && ((corners.corner - $past(corners.corner)) == 3'd1))
		else $error("corner beat missing or out of order");

	// the divider is busy after taking a cell id
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cells.valid && cells.ready |=> !cells.ready)
		else $error("front took a cell id while dividing");
`endif

endmodule

// ----- src/hcci_front.sv -----
module hcci_front (
	input  logic                            clk,
	input  logic                            arst_n,
	hcci_in_if.sink                         cells,
	input  logic [hcci_pkg::CNT_W-1:0]      nx_eff,
	input  logic [hcci_pkg::CNT_W-1:0]      ny_eff,
	input  logic [hcci_pkg::CNT_W-1:0]      nz_eff,
	input  logic [hcci_pkg::PX_W-1:0]       px,
	input  logic [hcci_pkg::PPLANE_W-1:0]   pplane,
	output logic                            push_valid,
	output hcci_pkg::cell_t                 push_data,
	input  logic                            push_ready
);

	localparam int CNT_W    = hcci_pkg::CNT_W;
	localparam int PID_W    = hcci_pkg::PID_W;
	localparam int PLANE_W  = hcci_pkg::PLANE_W;
	localparam int TOTAL_W  = hcci_pkg::TOTAL_W;
	localparam int DSH_W    = hcci_pkg::DSH_W;
	localparam int PK_W     = hcci_pkg::CNT_W + hcci_pkg::PPLANE_W;
	localparam int PJ_W     = hcci_pkg::CNT_W + hcci_pkg::PX_W;
	localparam int CYC_W    = $clog2(hcci_pkg::DIV_CYC);
	localparam logic [CYC_W-1:0] LAST_CYC = CYC_W'(hcci_pkg::DIV_CYC - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIVK = 3'd1;
	localparam logic [2:0] ST_DIVJ = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]                     state_q;
	logic [CYC_W-1:0]               cnt_q;
	logic [hcci_pkg::ID_W-1:0]      rem_q;
	logic [hcci_pkg::QUO_W-1:0]     quo_q;
	logic [DSH_W-1:0]               dsh_q;
	logic [PLANE_W-1:0]             plane_q;
	logic [CNT_W-1:0]               nx_q;
	logic [CNT_W-1:0]               nz_q;
	logic                           oor_q;
	logic [CNT_W-1:0]               ci_q;
	logic [CNT_W-1:0]               cj_q;
	logic [CNT_W-1:0]               ck_q;
	logic [PID_W-1:0]               prodk_q;
	logic [PJ_W-1:0]                prodj_q;

	logic                           accept;
	hcci_pkg::div_t                 step;
	logic [PLANE_W-1:0]             plane_c;
	logic [TOTAL_W-1:0]             total_c;
	logic [PK_W-1:0]                prodk_c;
	logic [PJ_W-1:0]                prodj_c;

	assign cells.ready = (state_q == ST_IDLE) || ((state_q == ST_DONE) && push_ready);
	assign accept      = cells.valid && cells.ready;

	assign step    = hcci_pkg::div_step(rem_q, dsh_q, quo_q);
	assign plane_c = PLANE_W'(nx_eff) * PLANE_W'(ny_eff);
	assign total_c = TOTAL_W'(plane_q) * TOTAL_W'(nz_q);
	assign prodk_c = PK_W'(ck_q) * PK_W'(pplane);
	assign prodj_c = PJ_W'(cj_q) * PJ_W'(px);

	assign push_valid     = (state_q == ST_DONE);
	assign push_data.oor  = oor_q;
	assign push_data.base = prodk_q + PID_W'(prodj_q) + PID_W'(ci_q);
	assign push_data.ci   = ci_q;
	assign push_data.cj   = cj_q;
	assign push_data.ck   = ck_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= ST_DIVK;
					end
				end
				ST_DIVK: begin
					if (cnt_q == LAST_CYC) begin
						state_q <= ST_DIVJ;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CYC_W'(1);
					end
				end
				ST_DIVJ: begin
					if (cnt_q == LAST_CYC) begin
						state_q <= ST_MUL;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CYC_W'(1);
					end
				end
				ST_MUL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= ST_DIVK;
					end else if (push_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q   <= cells.cell_id;
			quo_q   <= '0;
			dsh_q   <= DSH_W'(plane_c) << (hcci_pkg::QUO_W - 1);
			plane_q <= plane_c;
			nx_q    <= nx_eff;
			nz_q    <= nz_eff;
		end else begin
			case (state_q)
				ST_DIVK: begin
					rem_q <= step.rem;
					// rem still holds the id on the first cycle
					if (cnt_q == '0) begin
						oor_q <= (TOTAL_W'(rem_q) >= total_c);
					end
					if (cnt_q == LAST_CYC) begin
						ck_q  <= step.quo[CNT_W-1:0];
						quo_q <= '0;
						dsh_q <= DSH_W'(nx_q) << (hcci_pkg::QUO_W - 1);
					end else begin
						quo_q <= step.quo;
						dsh_q <= dsh_q >> hcci_pkg::DIV_STEPS;
					end
				end
				ST_DIVJ: begin
					rem_q <= step.rem;
					quo_q <= step.quo;
					dsh_q <= dsh_q >> hcci_pkg::DIV_STEPS;
					if (cnt_q == LAST_CYC) begin
						cj_q <= step.quo[CNT_W-1:0];
						ci_q <= step.rem[CNT_W-1:0];
					end
				end
				ST_MUL: begin
					prodk_q <= prodk_c[PID_W-1:0];
					prodj_q <= prodj_c;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- src/hcci_queue.sv -----
module hcci_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  hcci_pkg::cell_t push_data,
	output logic            push_ready,
	output logic            pop_valid,
	output hcci_pkg::cell_t pop_data,
	input  logic            pop
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	hcci_pkg::cell_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != (PTR_W + 1)'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (PTR_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (PTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- src/hcci_back.sv -----
module hcci_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	input  hcci_pkg::cell_t               pop_data,
	output logic                          pop,
	input  logic [hcci_pkg::PX_W-1:0]     px,
	input  logic [hcci_pkg::PPLANE_W-1:0] pplane,
	hcci_out_if.source                    corners
);

	localparam int CNT_W    = hcci_pkg::CNT_W;
	localparam int PX_W     = hcci_pkg::PX_W;
	localparam int PID_W    = hcci_pkg::PID_W;
	localparam int CK_W     = hcci_pkg::CK_W;
	localparam int CORNER_W = hcci_pkg::CORNER_W;

	logic                  busy_q;
	logic [CORNER_W-1:0]   corner_q;
	hcci_pkg::cell_t       item_q;
	logic                  out_valid_q;
	logic [CORNER_W-1:0]   out_corner_q;
	logic [PID_W-1:0]      out_pid_q;
	logic [CNT_W-1:0]      out_i_q;
	logic [CNT_W-1:0]      out_j_q;
	logic [CK_W-1:0]       out_k_q;
	logic                  out_oor_q;
	logic                  out_last_q;

	logic                  out_free;
	logic                  gen;
	logic                  is_last;
	logic                  di;
	logic                  dj;
	logic                  dk;
	logic [PX_W-1:0]       a_c;
	logic [PX_W-1:0]       b_c;
	logic [PX_W-1:0]       c_c;
	logic [PID_W-1:0]      pid_c;

	assign out_free = !out_valid_q || corners.ready;
	assign gen      = busy_q && out_free;
	assign is_last  = (corner_q == hcci_pkg::LAST_CORNER);
	assign pop      = pop_valid && (!busy_q || (gen && is_last));

	assign di = hcci_pkg::CORNER_DI[corner_q];
	assign dj = hcci_pkg::CORNER_DJ[corner_q];
	assign dk = hcci_pkg::CORNER_DK[corner_q];

	assign a_c   = PX_W'(item_q.ci) + PX_W'(di);
	assign b_c   = PX_W'(item_q.cj) + PX_W'(dj);
	assign c_c   = PX_W'(item_q.ck) + PX_W'(dk);
	// corners add one point, one row and one plane, as their offset bits say, to the base point id
	assign pid_c = item_q.base + (dk ? PID_W'(pplane) : '0) + (dj ? PID_W'(px) : '0)
		+ PID_W'(di);

	assign corners.valid        = out_valid_q;
	assign corners.corner       = out_corner_q;
	assign corners.point_id     = out_pid_q;
	assign corners.corner_i     = out_i_q;
	assign corners.corner_j     = out_j_q;
	assign corners.corner_k     = out_k_q;
	assign corners.out_of_range = out_oor_q;
	assign corners.last         = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			corner_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q   <= 1'b1;
				corner_q <= '0;
			end else if (gen) begin
				corner_q <= corner_q + CORNER_W'(1);
				if (is_last) begin
					busy_q <= 1'b0;
				end
			end
			if (gen) begin
				out_valid_q <= 1'b1;
			end else if (corners.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= pop_data;
		end
		if (gen) begin
			out_corner_q <= corner_q;
			out_pid_q    <= item_q.oor ? '0 : pid_c;
			out_i_q      <= item_q.oor ? '0 : a_c[CNT_W-1:0];
			out_j_q      <= item_q.oor ? '0 : b_c[CNT_W-1:0];
			out_k_q      <= item_q.oor ? '0 : CK_W'(c_c);
			out_oor_q    <= item_q.oor;
			out_last_q   <= is_last;
		end
	end

endmodule
